@@ src/sfd_pkg.sv @@
package sfd_pkg;

    // table geometry and count width
    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 16;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);
    localparam int CFG_IDX_BITS  = 8;

    localparam logic [USED_BITS-1:0]  ENTRIES_U = USED_BITS'(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // header codes
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam int          FLAG_SYN_BIT = 1;
    localparam int          FLAG_ACK_BIT = 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYNACK_MULT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYN_OFFSET  = CFG_IDX_BITS'(1);

    // sequencer to table
    typedef struct packed {
        logic [IDX_BITS-1:0]   rd_idx;
        logic                  wr_en;
        logic [IDX_BITS-1:0]   wr_idx;
        logic [31:0]           wr_addr;
        logic [COUNT_BITS-1:0] wr_tally;
        logic                  grow;
    } tbl_ctrl_t;

    // table to sequencer
    typedef struct packed {
        logic [31:0]           rd_addr;
        logic [COUNT_BITS-1:0] rd_tally;
        logic [USED_BITS-1:0]  used;
    } tbl_stat_t;

endpackage

@@ src/sfd_if.sv @@
// packet header word
interface sfd_pkt_if;
    logic        valid;
    logic        ready;
    logic [15:0] ether_kind;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  tcp_flag_bits;

    modport source (output valid, ether_kind, ip_protocol, source_address,
                    dest_address, tcp_flag_bits, input ready);
    modport sink   (input valid, ether_kind, ip_protocol, source_address,
                    dest_address, tcp_flag_bits, output ready);
endinterface

// result word
interface sfd_res_if;
    logic        valid;
    logic        ready;
    logic        flood_warning;
    logic [15:0] syn_seen;
    logic [15:0] synack_seen;
    logic        table_full;
    logic [31:0] warning_packets;
    logic [31:0] tcp_packets;
    logic [31:0] udp_packets;
    logic [31:0] icmp_packets;
    logic [31:0] arp_packets;

    modport source (output valid, flood_warning, syn_seen, synack_seen, table_full,
                    warning_packets, tcp_packets, udp_packets, icmp_packets,
                    arp_packets, input ready);
    modport sink   (input valid, flood_warning, syn_seen, synack_seen, table_full,
                    warning_packets, tcp_packets, udp_packets, icmp_packets,
                    arp_packets, output ready);
endinterface

// register write word
interface sfd_cfg_if;
    import sfd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [15:0]             data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sfd_table.sv @@
module sfd_table (
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::tbl_ctrl_t ctrl,
    output sfd_pkg::tbl_stat_t stat
);
    import sfd_pkg::*;

    logic [31:0]           addr_mem  [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] tally_mem [TABLE_ENTRIES];
    logic [31:0]           rd_addr_reg;
    logic [COUNT_BITS-1:0] rd_tally_reg;
    logic [USED_BITS-1:0]  used_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            addr_mem[ctrl.wr_idx]  <= ctrl.wr_addr;
            tally_mem[ctrl.wr_idx] <= ctrl.wr_tally;
        end
        rd_addr_reg  <= addr_mem[ctrl.rd_idx];
        rd_tally_reg <= tally_mem[ctrl.rd_idx];
    end

    // fill count; the detector matches no entry at or above it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctrl.grow)
        begin
            used_reg <= used_reg + USED_BITS'(1);
        end
    end

    assign stat.rd_addr  = rd_addr_reg;
    assign stat.rd_tally = rd_tally_reg;
    assign stat.used     = used_reg;

endmodule

@@ src/syn_flood_detector.sv @@
// A word that is neither SYN nor SYN-ACK goes from acceptance straight to the
// output state. A SYN makes two table scans at one entry per cycle through the
// shared address comparator, then multiplies, compares and updates; a SYN-ACK
// scans only the SYN-ACK table, then updates. One word is taken at a time.
// Reset (rst_n, async, active low) clears counters, fill counts and the
// sequencer; table contents stay undefined and are gated by the fill counts.
module syn_flood_detector (
    input  logic  clk,
    input  logic  rst_n,
    sfd_pkt_if.sink   pkt,
    sfd_res_if.source res,
    sfd_cfg_if.sink   cfg
);
    import sfd_pkg::*;

    localparam int PROD_BITS  = COUNT_BITS + 4;
    localparam int LIMIT_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 5;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MUL  = 6'b000100,
        S_CMP  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    function automatic logic [31:0] bump32(input logic [31:0] v);
        bump32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump_count(input logic [COUNT_BITS-1:0] v);
        bump_count = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] v);
        logic [15:0] r;
        if (COUNT_BITS > 16)
            r = (v > COUNT_BITS'(17'h0FFFF)) ? 16'hFFFF : 16'(v);
        else
            r = 16'(v);
        clip16 = r;
    endfunction

    state_t state_reg, state_next;

    logic [3:0]  mult_reg;
    logic [15:0] offset_reg;

    logic        is_syn_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;

    // scan control
    logic                 sel_synack_reg;
    logic [USED_BITS-1:0] issue_reg;
    logic                 pend_reg;
    logic [IDX_BITS-1:0]  pend_idx_reg;

    logic                  syn_hit_reg, ack_hit_reg;
    logic [IDX_BITS-1:0]   syn_idx_reg, ack_idx_reg;
    logic [COUNT_BITS-1:0] syn_cnt_reg, ack_cnt_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  warn_reg;
    logic                  full_reg;

    logic [31:0] warning_tally_reg, tcp_tally_reg, udp_tally_reg;
    logic [31:0] icmp_tally_reg, arp_tally_reg;

    // output register
    logic        res_valid_reg;
    logic        res_warn_reg;
    logic [15:0] res_syn_reg;
    logic [15:0] res_synack_reg;
    logic        res_full_reg;
    logic [31:0] res_warning_reg, res_tcp_reg, res_udp_reg, res_icmp_reg, res_arp_reg;

    tbl_ctrl_t syn_ctrl, ack_ctrl;
    tbl_stat_t syn_stat, ack_stat;

    logic pkt_fire, is_ipv4, is_tcp, syn_only, syn_ack;
    logic [31:0]          scan_key;
    tbl_stat_t            scan_stat;
    logic                 match, scan_done;
    logic [LIMIT_BITS-1:0] limit;
    logic                 over_limit;
    logic                 upd_hit;
    logic [IDX_BITS-1:0]  upd_idx;
    logic [COUNT_BITS-1:0] upd_cnt;
    logic [USED_BITS-1:0] upd_used;
    logic [31:0]          upd_key;
    logic                 upd_room;
    logic                 out_free;

    // header classification
    assign pkt.ready = (state_reg == S_IDLE);
    assign pkt_fire  = pkt.valid && pkt.ready;
    assign is_ipv4   = (pkt.ether_kind == ETH_IPV4);
    assign is_tcp    = is_ipv4 && (pkt.ip_protocol == PROTO_TCP);
    assign syn_only  = is_tcp && pkt.tcp_flag_bits[FLAG_SYN_BIT]
                       && !pkt.tcp_flag_bits[FLAG_ACK_BIT];
    assign syn_ack   = is_tcp && pkt.tcp_flag_bits[FLAG_SYN_BIT]
                       && pkt.tcp_flag_bits[FLAG_ACK_BIT];

    // shared address comparator over the selected table
    assign scan_key  = sel_synack_reg ? dst_reg : src_reg;
    assign scan_stat = sel_synack_reg ? ack_stat : syn_stat;
    assign match     = pend_reg && (scan_stat.rd_addr == scan_key);
    assign scan_done = match || (issue_reg >= scan_stat.used);

    // warning threshold
    assign limit      = LIMIT_BITS'(prod_reg) + LIMIT_BITS'(offset_reg);
    assign over_limit = LIMIT_BITS'(syn_cnt_reg) > limit;

    // update target: SYN table for a SYN, SYN-ACK table otherwise
    assign upd_hit  = is_syn_reg ? syn_hit_reg : ack_hit_reg;
    assign upd_idx  = is_syn_reg ? syn_idx_reg : ack_idx_reg;
    assign upd_cnt  = is_syn_reg ? syn_cnt_reg : ack_cnt_reg;
    assign upd_used = is_syn_reg ? syn_stat.used : ack_stat.used;
    assign upd_key  = is_syn_reg ? src_reg : dst_reg;
    assign upd_room = upd_used < ENTRIES_U;

    always_comb
    begin
        syn_ctrl.rd_idx   = issue_reg[IDX_BITS-1:0];
        syn_ctrl.wr_idx   = upd_hit ? upd_idx : upd_used[IDX_BITS-1:0];
        syn_ctrl.wr_addr  = upd_key;
        syn_ctrl.wr_tally = upd_hit ? bump_count(upd_cnt) : COUNT_BITS'(1);
        syn_ctrl.wr_en    = (state_reg == S_UPD) && is_syn_reg && (upd_hit || upd_room);
        syn_ctrl.grow     = (state_reg == S_UPD) && is_syn_reg && !upd_hit && upd_room;
        ack_ctrl          = syn_ctrl;
        ack_ctrl.wr_en    = (state_reg == S_UPD) && !is_syn_reg && (upd_hit || upd_room);
        ack_ctrl.grow     = (state_reg == S_UPD) && !is_syn_reg && !upd_hit && upd_room;
    end

    sfd_table u_syn_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (syn_ctrl),
        .stat  (syn_stat)
    );

    sfd_table u_synack_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ack_ctrl),
        .stat  (ack_stat)
    );

    assign out_free = !res_valid_reg || res.ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_fire)
                    state_next = (syn_only || syn_ack) ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                if (scan_done && sel_synack_reg)
                    state_next = is_syn_reg ? S_MUL : S_UPD;
            end
            S_MUL:  state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            warning_tally_reg <= '0;
            tcp_tally_reg     <= '0;
            udp_tally_reg     <= '0;
            icmp_tally_reg    <= '0;
            arp_tally_reg     <= '0;
            sel_synack_reg    <= 1'b0;
            issue_reg         <= '0;
            pend_reg          <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // word accept: latch header, bump protocol counters
            if (pkt_fire)
            begin
                is_syn_reg     <= syn_only;
                src_reg        <= pkt.source_address;
                dst_reg        <= pkt.dest_address;
                sel_synack_reg <= syn_ack;
                issue_reg      <= '0;
                pend_reg       <= 1'b0;
                syn_hit_reg    <= 1'b0;
                ack_hit_reg    <= 1'b0;
                syn_cnt_reg    <= '0;
                ack_cnt_reg    <= '0;
                warn_reg       <= 1'b0;
                full_reg       <= 1'b0;
                if (is_ipv4)
                begin
                    case (pkt.ip_protocol)
                        PROTO_TCP:  tcp_tally_reg  <= bump32(tcp_tally_reg);
                        PROTO_UDP:  udp_tally_reg  <= bump32(udp_tally_reg);
                        PROTO_ICMP: icmp_tally_reg <= bump32(icmp_tally_reg);
                        default: ;
                    endcase
                end
                else if (pkt.ether_kind == ETH_ARP)
                begin
                    arp_tally_reg <= bump32(arp_tally_reg);
                end
            end

            // table scan, one entry read per cycle
            if (state_reg == S_SCAN)
            begin
                if (!scan_done)
                begin
                    issue_reg    <= issue_reg + USED_BITS'(1);
                    pend_reg     <= 1'b1;
                    pend_idx_reg <= issue_reg[IDX_BITS-1:0];
                end
                else
                begin
                    issue_reg      <= '0;
                    pend_reg       <= 1'b0;
                    sel_synack_reg <= 1'b1;
                    if (!sel_synack_reg)
                    begin
                        syn_hit_reg <= match;
                        syn_idx_reg <= pend_idx_reg;
                        syn_cnt_reg <= match ? scan_stat.rd_tally : '0;
                    end
                    else
                    begin
                        ack_hit_reg <= match;
                        ack_idx_reg <= pend_idx_reg;
                        ack_cnt_reg <= match ? scan_stat.rd_tally : '0;
                    end
                end
            end

            if (state_reg == S_MUL)
                prod_reg <= PROD_BITS'(mult_reg) * PROD_BITS'(ack_cnt_reg);

            if ((state_reg == S_CMP) && over_limit)
            begin
                warn_reg          <= 1'b1;
                warning_tally_reg <= bump32(warning_tally_reg);
            end

            if (state_reg == S_UPD)
                full_reg <= !upd_hit && !upd_room;

            // output register; SYN-ACK words report no lookups
            if ((state_reg == S_OUT) && out_free)
            begin
                res_valid_reg   <= 1'b1;
                res_warn_reg    <= warn_reg;
                res_syn_reg     <= clip16(syn_cnt_reg);
                res_synack_reg  <= is_syn_reg ? clip16(ack_cnt_reg) : 16'h0000;
                res_full_reg    <= full_reg;
                res_warning_reg <= warning_tally_reg;
                res_tcp_reg     <= tcp_tally_reg;
                res_udp_reg     <= udp_tally_reg;
                res_icmp_reg    <= icmp_tally_reg;
                res_arp_reg     <= arp_tally_reg;
            end
            else if (res.valid && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg   <= 4'd3;
            offset_reg <= 16'd3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_SYNACK_MULT: mult_reg   <= cfg.data[3:0];
                CFG_SYN_OFFSET:  offset_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.flood_warning   = res_warn_reg;
    assign res.syn_seen        = res_syn_reg;
    assign res.synack_seen     = res_synack_reg;
    assign res.table_full      = res_full_reg;
    assign res.warning_packets = res_warning_reg;
    assign res.tcp_packets     = res_tcp_reg;
    assign res.udp_packets     = res_udp_reg;
    assign res.icmp_packets    = res_icmp_reg;
    assign res.arp_packets     = res_arp_reg;

endmodule
